/* rtl/pli_pkg.sv */
// shared types and constants of the piecewise linear interpolator
package pli_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_APPEND   = 2'd1,
      OP_EVALUATE = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_MATCH = 2'd1,
      STATUS_FEW      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_ADDR,
      ST_SCAN,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_MUL0,
      ST_MUL1,
      ST_DIV,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic append;
      logic load_query;
      logic scan_start;
      logic scan_step;
      logic fetch_sel;
      logic fetch_next;
      logic latch_pair;
      logic mul_lo;
      logic mul_hi;
      logic div_start;
      logic emit;
      logic emit_few;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic few_points;
      logic scan_last;
      logic div_done;
   } stat_type;

endpackage

/* rtl/pli_ctrl.sv */
// controller state machine of the piecewise linear interpolator
module pli_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_op,
   input  pli_pkg::stat_type stat,
   output pli_pkg::cmd_type  cmd,
   output logic              busy
);

   pli_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != pli_pkg::ST_IDLE);
      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_op)
                  pli_pkg::OP_CLEAR:  cmd.clear = 1'b1;
                  pli_pkg::OP_APPEND: cmd.append = 1'b1;
                  pli_pkg::OP_EVALUATE: begin
                     cmd.load_query = 1'b1;
                     if (stat.few_points) begin
                        cmd.emit_few = 1'b1;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in = pli_pkg::ST_SCAN_ADDR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pli_pkg::ST_SCAN_ADDR: state_in = pli_pkg::ST_SCAN;
         pli_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = pli_pkg::ST_FETCH0;
         end
         pli_pkg::ST_FETCH0: begin
            cmd.fetch_sel = 1'b1;
            state_in = pli_pkg::ST_FETCH1;
         end
         pli_pkg::ST_FETCH1: begin
            cmd.fetch_next = 1'b1;
            state_in = pli_pkg::ST_FETCH2;
         end
         pli_pkg::ST_FETCH2: begin
            cmd.latch_pair = 1'b1;
            state_in = pli_pkg::ST_MUL0;
         end
         pli_pkg::ST_MUL0: begin
            cmd.mul_lo = 1'b1;
            state_in = pli_pkg::ST_MUL1;
         end
         pli_pkg::ST_MUL1: begin
            cmd.mul_hi = 1'b1;
            state_in = pli_pkg::ST_DIV;
         end
         pli_pkg::ST_DIV: begin
            if (stat.div_done) state_in = pli_pkg::ST_DONE;
         end
         pli_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = pli_pkg::ST_IDLE;
         end
         default: state_in = pli_pkg::ST_IDLE;
      endcase
      if (state_ff == pli_pkg::ST_MUL1) cmd.div_start = 1'b1;
   end

   a_scan_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> busy) else $error("scan step while idle");
   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == pli_pkg::ST_IDLE) else $error("emit not followed by idle");
   a_div_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == pli_pkg::ST_DIV |-> $past(state_ff) == pli_pkg::ST_MUL1
      || $past(state_ff) == pli_pkg::ST_DIV) else $error("divide entered out of order");

endmodule

/* rtl/pli_datapath.sv */
// table memories, scan, multiply and divide of the piecewise linear interpolator
module pli_datapath #(
   parameter int MAX_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  pli_pkg::cmd_type   cmd,
   output pli_pkg::stat_type  stat,
   input  logic [7:0]         limit,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] query_x,
   output logic               result_valid,
   output logic signed [31:0] result_y,
   output logic [1:0]         result_status
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [31:0] x_mem [MAX_POINTS];
   logic [31:0] y_mem [MAX_POINTS];

   logic [CW-1:0] count_ff;
   logic [AW-1:0] raddr;
   logic signed [31:0] rx_ff, ry_ff;

   logic signed [31:0] query_ff;
   logic [AW-1:0] scan_ff;       // index of the segment under test
   logic signed [31:0] prev_x_ff;
   logic [7:0] hits_ff;
   logic found_ff;
   logic [AW-1:0] sel_ff;

   logic signed [31:0] x0_ff, y0_ff;
   logic [32:0] dx_ff, dq_ff, mag_ff;
   logic neg_ff;
   logic [48:0] plo_ff;

   logic [63:0] quo_ff;
   logic [32:0] rem_ff;
   logic [6:0] div_cnt_ff;
   logic div_run_ff;

   logic valid_ff;
   logic signed [31:0] res_ff;
   logic [1:0] stat_ff;

   // read address follows the controller step; while scanning, fetch two ahead
   always_comb begin
      priority if (cmd.scan_start) raddr = '0;
      else if (cmd.fetch_sel)      raddr = sel_ff;
      else if (cmd.fetch_next)     raddr = sel_ff + AW'(1);
      else if (cmd.scan_step)      raddr = scan_ff + AW'(2);
      else                         raddr = scan_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.append && count_ff < CW'(MAX_POINTS)) begin
         x_mem[count_ff[AW-1:0]] <= point_x;
         y_mem[count_ff[AW-1:0]] <= point_y;
      end
      rx_ff <= x_mem[raddr];
      ry_ff <= y_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.append && count_ff < CW'(MAX_POINTS)) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   logic [CW-1:0] scan_ext;
   assign scan_ext = CW'(scan_ff);
   assign stat.few_points = count_ff < CW'(2);
   assign stat.scan_last  = (scan_ext + CW'(1)) == count_ff - CW'(1);
   assign stat.div_done   = div_run_ff && div_cnt_ff == 7'd0;

   logic hit;
   assign hit = (query_ff >= prev_x_ff) && (query_ff <= rx_ff) && (hits_ff < limit);

   always_ff @(posedge clock) begin
      if (cmd.load_query) query_ff <= query_x;
      if (cmd.scan_start) begin
         scan_ff  <= '0;
         hits_ff  <= '0;
         found_ff <= 1'b0;
         sel_ff   <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + AW'(1);
         if (hit) begin
            sel_ff   <= scan_ff;
            found_ff <= 1'b1;
            hits_ff  <= hits_ff + 8'd1;
         end
      end
      prev_x_ff <= rx_ff;
      if (cmd.fetch_next) begin
         x0_ff <= rx_ff;
         y0_ff <= ry_ff;
      end
      if (cmd.latch_pair) begin
         dx_ff  <= 33'(34'(rx_ff) - 34'(x0_ff));
         dq_ff  <= 33'(34'(query_ff) - 34'(x0_ff));
         neg_ff <= ry_ff < y0_ff;
         mag_ff <= (ry_ff < y0_ff) ? 33'({y0_ff[31], y0_ff} - {ry_ff[31], ry_ff})
                                   : 33'({ry_ff[31], ry_ff} - {y0_ff[31], y0_ff});
      end
      // 33 x 33 product split into two 33 x 16/17 halves
      if (cmd.mul_lo) plo_ff <= 49'(mag_ff) * 49'(dq_ff[15:0]);
   end

   // restoring divider, one quotient bit a cycle
   logic [33:0] trial;
   assign trial = {rem_ff, quo_ff[63]} - {1'b0, dx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_run_ff <= 1'b1;
      end else if (div_run_ff && div_cnt_ff == 7'd0) begin
         div_run_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         div_cnt_ff <= 7'd64;
         rem_ff     <= '0;
      end else if (div_run_ff && div_cnt_ff != 7'd0) begin
         div_cnt_ff <= div_cnt_ff - 7'd1;
         if (!trial[33]) begin
            rem_ff <= trial[32:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], quo_ff[63]};
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.mul_hi) quo_ff <= 64'(plo_ff) + 64'((64'(mag_ff) * 64'(dq_ff[32:16])) << 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit || cmd.emit_few;
      end
      if (cmd.emit_few) begin
         res_ff  <= '0;
         stat_ff <= pli_pkg::STATUS_FEW;
      end else if (cmd.emit) begin
         if (!found_ff) begin
            res_ff  <= '0;
            stat_ff <= pli_pkg::STATUS_NO_MATCH;
         end else begin
            stat_ff <= pli_pkg::STATUS_OK;
            if (dx_ff == '0)  res_ff <= y0_ff;
            else if (neg_ff)  res_ff <= y0_ff - $signed(quo_ff[31:0]);
            else              res_ff <= y0_ff + $signed(quo_ff[31:0]);
         end
      end
   end

   assign result_valid  = valid_ff;
   assign result_y      = res_ff;
   assign result_status = stat_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count beyond table");
   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> hits_ff <= limit) else $error("hits beyond limit");
   a_prod_unused: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> div_run_ff) else $error("divider did not start");

endmodule

/* rtl/piecewise_linear_interpolator.sv */
// top level of the piecewise linear interpolator
//
// a table of up to MAX_POINTS (x, y) points in signed q16.16 is loaded by clear
// and append transfers; an evaluate transfer scans every stored segment, keeps the
// last match among the first csr_occurrence_limit matches, and interpolates y.
// clear, append and ignored ops give no result. an evaluate keeps busy high through
// the ST_SCAN_ADDR setup state, a ST_SCAN step per segment on the table read port, the
// ST_FETCH0 to ST_FETCH2 fetch states, the ST_MUL0 and ST_MUL1 multiply states, the
// bit-serial divider (64 quotient bits and a done check) and the ST_DONE output state;
// the result shows in the cycle after busy falls, when a new transfer may already be
// taken. with fewer than two points it answers in the cycle after the transfer and
// busy stays low. each result shows for one cycle with rsp_valid; the receiver cannot
// stall, so it must take it then. the table needs no clearing pass after reset.
module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_y,
   output logic [1:0]         rsp_status,
   input  logic               csr_write,
   input  logic [7:0]         csr_occurrence_limit
);

   pli_pkg::cmd_type  cmd;
   pli_pkg::stat_type stat;

   // occurrence limit register
   logic [7:0] limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 8'd1;
      end else if (csr_write) begin
         limit_ff <= csr_occurrence_limit;
      end
   end

   pli_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   pli_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .limit         (limit_ff),
      .point_x       (req_point_x),
      .point_y       (req_point_y),
      .query_x       (req_query_x),
      .result_valid  (rsp_valid),
      .result_y      (rsp_result_y),
      .result_status (rsp_status)
   );

endmodule
